// File: sv/stack_with_match_removal_assert.svh
// Assertion macros shared by the checker of the match-removal stack.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef STACK_WITH_MATCH_REMOVAL_ASSERT_SVH
`define STACK_WITH_MATCH_REMOVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SWMR_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("stack assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SWMR_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("stack assertion failed");

`endif

// File: sv/swmr_pkg.sv
// Shared types and constants for the match-removal stack.
// Used by the cell, the top level and the checker; depends on nothing.
package swmr_pkg;

  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Control broadcast from the top level to every cell in the row.
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic                     remove;
    logic signed [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: sv/swmr_cell.sv
// One storage cell of the match-removal stack row.
// Depends on swmr_pkg for the control struct and the word width.
module swmr_cell (
  input  logic                               clk,
  input  swmr_pkg::cell_ctrl_t               ctrl,
  input  logic                               occupied,
  input  logic signed [swmr_pkg::WORD_W-1:0] up_data,
  input  logic signed [swmr_pkg::WORD_W-1:0] down_data,
  input  logic                               found_in,
  output logic                               found_out,
  output logic signed [swmr_pkg::WORD_W-1:0] data_out
);
  import swmr_pkg::*;

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;
  logic                     hit;

  // A cell at or below the first match nearest the top moves up by one place.
  assign hit       = ctrl.remove & occupied & (data_r == ctrl.value);
  assign found_out = found_in | hit;
  assign data_out  = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = up_data;
    end else if (ctrl.pop || (ctrl.remove && found_out)) begin
      data_nxt = down_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: sv/stack_with_match_removal.sv
// Match-removal stack: a row of DEPTH cells, cell 0 holding the top entry.
// The result is registered and appears in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle outside reset; push, pop, peek and
// remove each finish in the cycle of acceptance, the match search running
// along the row. Reset (synchronous, active low) empties the stack and
// clears the strobe; busy is high only while reset is held. Depends on swmr_pkg and swmr_cell.
module stack_with_match_removal #(
  parameter int DEPTH = swmr_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_req_type,
  input  logic signed [swmr_pkg::WORD_W-1:0] in_value,
  output logic                               out_valid,
  output logic signed [swmr_pkg::WORD_W-1:0] out_result_value,
  output logic [1:0]                         out_status,
  output logic [CNT_W-1:0]                   out_depth_now
);
  import swmr_pkg::*;

  // The stack is held as a row of cells indexed from the top, so a push
  // shifts every entry one cell away from the top and a pop or a removal
  // shifts the entries below the removed one a cell towards it.
  logic                     accept;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     empty;
  logic                     full;
  logic                     found;
  cell_ctrl_t               ctrl;
  logic [1:0]               status_nxt;
  logic signed [WORD_W-1:0] result_nxt;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_result_value_r;
  logic [1:0]               out_status_r;
  logic [CNT_W-1:0]         out_depth_now_r;

  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic                     found_chain [DEPTH+1];

  // No transaction can be taken while reset is held.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  // Broadcast control: push and pop are gated here so that a refused
  // transaction leaves every cell untouched.
  always_comb begin
    ctrl.push   = accept && (in_req_type == REQ_PUSH) && !full;
    ctrl.pop    = accept && (in_req_type == REQ_POP) && !empty;
    ctrl.remove = accept && (in_req_type == REQ_REMOVE);
    ctrl.value  = in_value;
  end

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] up_data;
    logic signed [WORD_W-1:0] down_data;
    logic                     occupied;

    assign occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_top
      assign up_data = in_value;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
    end

    // The bottom cell has nothing beneath it; it keeps its own word, which
    // then lies beyond the fill count and is never read.
    if (i == DEPTH - 1) begin : g_bot
      assign down_data = cell_data[i];
    end else begin : g_up
      assign down_data = cell_data[i+1];
    end

    swmr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occupied),
      .up_data   (up_data),
      .down_data (down_data),
      .found_in  (found_chain[i]),
      .found_out (found_chain[i+1]),
      .data_out  (cell_data[i])
    );
  end

  assign found = found_chain[DEPTH];

  // Result and new fill count. A removed entry equals the search word, so
  // the search word itself is returned.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    result_nxt = '0;
    case (req_t'(in_req_type))
      REQ_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          result_nxt = cell_data[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      REQ_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          result_nxt = cell_data[0];
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          result_nxt = in_value;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload needs no reset; the strobe qualifies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_result_value_r <= result_nxt;
      out_status_r       <= status_nxt;
      out_depth_now_r    <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_status       = out_status_r;
  assign out_depth_now    = out_depth_now_r;

endmodule

// File: sv/swmr_checker.sv
// Port-level checker for the match-removal stack, bound to the top level.
// Depends on swmr_pkg and the assertion macros in the shared header.
`include "stack_with_match_removal_assert.svh"

module swmr_checker #(
  parameter int DEPTH = swmr_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [swmr_pkg::WORD_W-1:0] out_result_value,
  input logic [1:0]                         out_status,
  input logic [CNT_W-1:0]                   out_depth_now
);
  import swmr_pkg::*;

  // Every accepted transaction gives its result in the next cycle.
  `SWMR_ASSERT_NXT(a_result_follows, start && !busy, out_valid)

  // No result appears without a transaction accepted in the cycle before.
  `SWMR_ASSERT_IMP(a_no_spurious, out_valid, $past(start && !busy && rst_n))

  // Any status other than ok carries a zero word.
  `SWMR_ASSERT_IMP(a_zero_on_error, out_valid && (out_status != ST_OK),
                   out_result_value == '0)

  // A refused push is reported only when the stack is at capacity.
  `SWMR_ASSERT_IMP(a_full_depth, out_valid && (out_status == ST_FULL),
                   out_depth_now == CNT_W'(DEPTH))

  // An empty report leaves the stack with nothing in it.
  `SWMR_ASSERT_IMP(a_empty_depth, out_valid && (out_status == ST_EMPTY),
                   out_depth_now == '0)

endmodule

bind stack_with_match_removal swmr_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_swmr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_status       (out_status),
  .out_depth_now    (out_depth_now)
);
